@@ rtl/ccd_pkg.sv @@
// Shared types and constants of the contact crossing detector.
// Used by the controller, the datapath, the divider and the top level.
package ccd_pkg;

  localparam int HEIGHT_W  = 16;
  localparam int TIME_W    = 32;
  localparam int INTEN_W   = 9;
  localparam int DIV_W     = 24;
  localparam int DIV_CNT_W = 5;
  localparam int PROD_W    = 48;
  localparam int DEN_W     = 52;
  localparam int EVT_CNT_W = 6;
  localparam int MIN_SAMPLES = 3;
  localparam int THR_PROD_W  = 32;
  localparam int THR_SHIFT   = 18;

  localparam logic [EVT_CNT_W-1:0] RESULT_LIMIT = 6'd32;
  localparam logic [INTEN_W-1:0]   INTEN_MIN    = 9'd51;
  localparam logic [INTEN_W-1:0]   INTEN_MAX    = 9'd256;
  localparam logic [INTEN_W-1:0]   INTEN_FIXED  = 9'd128;
  localparam logic [16:0]          THR_RECIP    = 17'd52429;

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MOST_POS = 16'sh7FFF;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MOST_NEG = 16'sh8000;

  typedef enum logic [1:0] {
    PEND_FIXED,
    PEND_FLOOR,
    PEND_QUOT
  } ccd_pend_src_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_THR_WAIT,
    ST_FETCH,
    ST_EVAL,
    ST_FLUSH,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE,
    ST_LAST,
    ST_CLEAR
  } ccd_state_t;

  typedef struct packed {
    logic          load;
    logic          clip_clear;
    logic          scan_init;
    logic          div_start;
    logic          thr_latch;
    logic          advance;
    logic          pend_set;
    ccd_pend_src_t pend_src;
    logic          pend_clr;
  } ccd_cmd_t;

  typedef struct packed {
    logic short_trk;
    logic flat;
    logic crossing;
    logic pending;
    logic t_nonpos;
    logic den_big;
    logic div_done;
    logic scan_end;
  } ccd_stat_t;

endpackage

@@ rtl/ccd_if.sv @@
// Handshake channels of the contact crossing detector: sample words in,
// event words out. No dependencies.
interface ccd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] bone_height;
  logic        [31:0] sample_time;
  logic               final_sample;

  modport source (output valid, output bone_height, output sample_time,
                  output final_sample, input ready);
  modport sink   (input valid, input bone_height, input sample_time,
                  input final_sample, output ready);
endinterface

interface ccd_event_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_time;
  logic [8:0]  event_intensity;
  logic        overflow_seen;
  logic        last_event;

  modport source (output valid, output event_time, output event_intensity,
                  output overflow_seen, output last_event, input ready);
  modport sink   (input valid, input event_time, input event_intensity,
                  input overflow_seen, input last_event, output ready);
endinterface

@@ rtl/contact_crossing_detector.sv @@
// Contact crossing detector, top level: ties the controller to the datapath.
// Depends on ccd_pkg, ccd_if, ccd_ctrl and ccd_datapath.
//
// Usage: sample words enter on in_smp (height, timestamp, final flag) and are
// stored one per cycle, up to MAX_SAMPLES; later samples of the clip are
// dropped and reported through overflow_seen. The word with final_sample set
// starts the analysis, and in_smp.ready stays low until the clip is done.
// The analysis finds the threshold by a reciprocal multiply, reads and
// checks each stored sample, and works out each crossing with rising time
// by a multiply, a scale and a 24-step divide. A held event is handed over
// before the next crossing is taken on. Events leave on out_evt one at a
// time from an output register, in sample order, at most 32 per clip, the
// last one marked by last_event. An event is held until the next crossing or
// the end of the walk shows whether it is the last. When the receiver stalls,
// the walk waits with the event held stable. After the clip ends, the block
// clears it, then takes samples again. Reset (rst_n low, synchronous)
// empties the clip and returns to loading.
module contact_crossing_detector import ccd_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  ccd_sample_if.sink   in_smp,
  ccd_event_if.source  out_evt
);

  ccd_cmd_t  cmd;
  ccd_stat_t stat;

  ccd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_smp.valid),
    .in_final  (in_smp.final_sample),
    .in_ready  (in_smp.ready),
    .out_valid (out_evt.valid),
    .out_ready (out_evt.ready),
    .out_last  (out_evt.last_event),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccd_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_height       (in_smp.bone_height),
    .in_time         (in_smp.sample_time),
    .event_time      (out_evt.event_time),
    .event_intensity (out_evt.event_intensity),
    .overflow_seen   (out_evt.overflow_seen)
  );

endmodule

@@ rtl/ccd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ccd_pkg for its widths.
module ccd_div import ccd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (!diff[DIV_W]) begin
        rem_r <= diff[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/ccd_datapath.sv @@
// Datapath: sample stores, extremes, threshold, intensity arithmetic and the
// pending event register. Depends on ccd_pkg and instantiates ccd_div.
module ccd_datapath import ccd_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ccd_cmd_t                   cmd,
  output ccd_stat_t                  stat,
  input  logic signed [HEIGHT_W-1:0] in_height,
  input  logic        [TIME_W-1:0]   in_time,
  output logic        [TIME_W-1:0]   event_time,
  output logic        [INTEN_W-1:0]  event_intensity,
  output logic                       overflow_seen
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] DEPTH = CW'(MAX_SAMPLES);

  logic signed [HEIGHT_W-1:0] hmem [MAX_SAMPLES];
  logic        [TIME_W-1:0]   tmem [MAX_SAMPLES];

  logic        [CW-1:0]        count_r;
  logic signed [HEIGHT_W-1:0]  lo_r;
  logic signed [HEIGHT_W-1:0]  hi_r;
  logic                        drop_r;
  logic        [AW-1:0]        idx_r;
  logic        [EVT_CNT_W-1:0] n_r;
  logic                        pend_r;
  logic                        was_above_r;
  logic signed [HEIGHT_W:0]    thr_r;
  logic        [THR_PROD_W-1:0] thr_prod_r;
  logic signed [HEIGHT_W-1:0]  rd_h_r;
  logic        [TIME_W-1:0]    rd_t_r;
  logic signed [HEIGHT_W-1:0]  prev_h_r;
  logic        [TIME_W-1:0]    prev_t_r;
  logic        [PROD_W-1:0]    prod_r;
  logic        [DEN_W-1:0]     den_r;
  logic        [TIME_W-1:0]    pend_t_r;
  logic        [INTEN_W-1:0]   pend_i_r;

  logic                        store_ok;
  logic        [HEIGHT_W:0]    span;
  logic        [HEIGHT_W-1:0]  range_w;
  logic        [HEIGHT_W+1:0]  range3;
  logic        [HEIGHT_W-1:0]  range_q;
  logic        [HEIGHT_W:0]    hdiff;
  logic        [TIME_W-1:0]    dt;
  logic                        is_above;
  logic        [DIV_W-1:0]     div_dividend;
  logic        [DIV_W-1:0]     div_divisor;
  logic                        div_done;
  logic        [DIV_W-1:0]     quot;
  logic        [INTEN_W-1:0]   quot_clamped;
  logic        [INTEN_W-1:0]   pend_i_nxt;

  assign store_ok = (count_r != DEPTH);
  assign span     = {hi_r[HEIGHT_W-1], hi_r} - {lo_r[HEIGHT_W-1], lo_r};
  assign range_w  = span[HEIGHT_W-1:0];
  assign range3   = {2'b00, range_w} + {1'b0, range_w, 1'b0};
  assign range_q  = range3[HEIGHT_W+1:2];
  assign hdiff    = {prev_h_r[HEIGHT_W-1], prev_h_r} - {rd_h_r[HEIGHT_W-1], rd_h_r};
  assign dt       = rd_t_r - prev_t_r;
  assign is_above = $signed({rd_h_r[HEIGHT_W-1], rd_h_r}) > thr_r;

  assign div_dividend = {hdiff[HEIGHT_W-1:0], 8'h00};
  assign div_divisor  = den_r[DIV_W-1:0];

  ccd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (quot < {15'b0, INTEN_MIN}) begin
      quot_clamped = INTEN_MIN;
    end else if (quot > {15'b0, INTEN_MAX}) begin
      quot_clamped = INTEN_MAX;
    end else begin
      quot_clamped = quot[INTEN_W-1:0];
    end
  end

  always_comb begin
    case (cmd.pend_src)
      PEND_FLOOR: pend_i_nxt = INTEN_MIN;
      PEND_QUOT:  pend_i_nxt = quot_clamped;
      default:    pend_i_nxt = INTEN_FIXED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      hmem[count_r[AW-1:0]] <= in_height;
      tmem[count_r[AW-1:0]] <= in_time;
    end
    rd_h_r <= hmem[idx_r];
    rd_t_r <= tmem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clip_clear) begin
      count_r <= '0;
      lo_r    <= HEIGHT_MOST_POS;
      hi_r    <= HEIGHT_MOST_NEG;
      drop_r  <= 1'b0;
    end else if (cmd.load) begin
      if (store_ok) begin
        count_r <= count_r + 1'b1;
        if (in_height < lo_r) begin
          lo_r <= in_height;
        end
        if (in_height > hi_r) begin
          hi_r <= in_height;
        end
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      n_r         <= '0;
      pend_r      <= 1'b0;
      was_above_r <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        idx_r  <= '0;
        n_r    <= '0;
        pend_r <= 1'b0;
      end
      if (cmd.advance) begin
        idx_r       <= idx_r + 1'b1;
        was_above_r <= is_above;
      end
      if (cmd.pend_set) begin
        pend_r <= 1'b1;
        n_r    <= n_r + 1'b1;
      end else if (cmd.pend_clr) begin
        pend_r <= 1'b0;
      end
    end
  end

  // The threshold offset floor(range * 3 / 20) is floor((range * 3 / 4) / 5),
  // the division by five done by a reciprocal multiplication.
  always_ff @(posedge clk) begin
    thr_prod_r <= {16'b0, range_q} * {15'b0, THR_RECIP};
    if (cmd.thr_latch) begin
      thr_r <= {lo_r[HEIGHT_W-1], lo_r} + {3'b000, thr_prod_r[THR_PROD_W-1:THR_SHIFT]};
    end
    if (cmd.advance) begin
      prev_h_r <= rd_h_r;
      prev_t_r <= rd_t_r;
    end
    if (cmd.pend_set) begin
      pend_t_r <= rd_t_r;
      pend_i_r <= pend_i_nxt;
    end
    prod_r <= {16'b0, dt} * {32'b0, range_w};
    den_r  <= {1'b0, prod_r, 3'b000} + {3'b000, prod_r, 1'b0};
  end

  assign stat.short_trk = (count_r < CW'(MIN_SAMPLES));
  assign stat.flat      = !(hi_r > lo_r);
  assign stat.crossing  = (idx_r != '0) && was_above_r && !is_above &&
                          (n_r != RESULT_LIMIT);
  assign stat.pending   = pend_r;
  assign stat.t_nonpos  = (rd_t_r <= prev_t_r);
  assign stat.den_big   = |den_r[DEN_W-1:DIV_W];
  assign stat.div_done  = div_done;
  assign stat.scan_end  = (CW'(idx_r) == count_r - 1'b1);

  assign event_time      = pend_t_r;
  assign event_intensity = pend_i_r;
  assign overflow_seen   = drop_r;

endmodule

@@ rtl/ccd_ctrl.sv @@
// Controller state machine: sample loading, threshold, store walk and event
// delivery. Depends on ccd_pkg.
module ccd_ctrl import ccd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_final,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_last,
  input  ccd_stat_t stat,
  output ccd_cmd_t  cmd
);

  ccd_state_t state_r;
  ccd_state_t state_nxt;
  ccd_state_t step_nxt;

  assign step_nxt = stat.scan_end ? ST_DONE : ST_FETCH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_final) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (stat.short_trk || stat.flat) ? ST_CLEAR : ST_THR_WAIT;
      end
      ST_THR_WAIT: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.crossing) begin
          if (stat.pending) begin
            state_nxt = ST_FLUSH;
          end else if (stat.t_nonpos) begin
            state_nxt = step_nxt;
          end else begin
            state_nxt = ST_MUL;
          end
        end else begin
          state_nxt = step_nxt;
        end
      end
      ST_FLUSH: begin
        if (out_ready) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_nxt = stat.den_big ? step_nxt : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = step_nxt;
        end
      end
      ST_DONE: begin
        state_nxt = stat.pending ? ST_LAST : ST_CLEAR;
      end
      ST_LAST: begin
        if (out_ready) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.scan_init = 1'b1;
      end
      ST_THR_WAIT: begin
        cmd.thr_latch = 1'b1;
      end
      ST_EVAL: begin
        if (stat.crossing) begin
          if (!stat.pending && stat.t_nonpos) begin
            cmd.pend_set = 1'b1;
            cmd.pend_src = PEND_FIXED;
            cmd.advance  = 1'b1;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_FLUSH: begin
        out_valid    = 1'b1;
        cmd.pend_clr = out_ready;
      end
      ST_DIV_START: begin
        if (stat.den_big) begin
          cmd.pend_set = 1'b1;
          cmd.pend_src = PEND_FLOOR;
          cmd.advance  = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.pend_set = 1'b1;
          cmd.pend_src = PEND_QUOT;
          cmd.advance  = 1'b1;
        end
      end
      ST_LAST: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
      end
      ST_CLEAR: begin
        cmd.clip_clear = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
